/* design/fmd_pkg.sv */
// ----------------------------------------------------------------------------
// fmd_pkg
// shared widths, register indexes and the divider lane type of the fuzzy
// membership degree block
// ----------------------------------------------------------------------------
package fmd_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int FRAC_BITS   = 15;
    localparam int DEG_W       = FRAC_BITS + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = VALUE_WIDTH;
    localparam int NUM_LANES   = 2;

    localparam logic [DEG_W-1:0] ONE_DEG = DEG_W'(1) << FRAC_BITS;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_A = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_B = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_C = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_D = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_SHAPE   = CFG_INDEX_W'(4);

    // lane positions
    localparam int LANE_UP   = 0;
    localparam int LANE_DOWN = 1;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] point_a;
        logic signed [VALUE_WIDTH-1:0] point_b;
        logic signed [VALUE_WIDTH-1:0] point_c;
        logic signed [VALUE_WIDTH-1:0] point_d;
        logic                          shape_is_trap;
    } fmd_cfg_t;

    typedef struct packed {
        logic                   fixed;
        logic                   fixed_one;
        logic [VALUE_WIDTH-1:0] rem;
        logic [VALUE_WIDTH-1:0] den;
        logic [FRAC_BITS-1:0]   quo;
    } fmd_lane_t;

    typedef fmd_lane_t [NUM_LANES-1:0] fmd_lanes_t;

    function automatic logic [DEG_W-1:0] lane_degree(input fmd_lane_t lane);
        logic [DEG_W-1:0] deg;
        if (lane.fixed)
        begin
            deg = lane.fixed_one ? ONE_DEG : '0;
        end
        else
        begin
            deg = {1'b0, lane.quo};
        end
        return deg;
    endfunction

endpackage

/* design/fmd_in_if.sv */
// ----------------------------------------------------------------------------
// fmd_in_if
// input item channel: one signed crisp value per item
// ----------------------------------------------------------------------------
interface fmd_in_if;
    import fmd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] crisp_value;

    modport source (output valid, output crisp_value, input ready);
    modport sink   (input valid, input crisp_value, output ready);
endinterface

/* design/fmd_out_if.sv */
// ----------------------------------------------------------------------------
// fmd_out_if
// result item channel: one membership degree per item
// ----------------------------------------------------------------------------
interface fmd_out_if;
    import fmd_pkg::*;

    logic             valid;
    logic             ready;
    logic [DEG_W-1:0] degree;

    modport source (output valid, output degree, input ready);
    modport sink   (input valid, input degree, output ready);
endinterface

/* design/fmd_prep.sv */
// ----------------------------------------------------------------------------
// fmd_prep
// classifies both edges of the set for one item and loads the divider lanes
// ----------------------------------------------------------------------------
module fmd_prep (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  valid_in,
    input  logic signed [fmd_pkg::VALUE_WIDTH-1:0] crisp_value,
    input  fmd_pkg::fmd_cfg_t                     cfg,
    output logic                                  valid_out,
    output fmd_pkg::fmd_lanes_t                   lanes_out
);
    import fmd_pkg::*;

    logic       valid_reg;
    fmd_lanes_t lanes_reg;
    fmd_lanes_t lanes_next;

    logic signed [VALUE_WIDTH-1:0] fall_lo;
    logic signed [VALUE_WIDTH-1:0] fall_hi;

    function automatic logic [VALUE_WIDTH-1:0] diff(
        input logic signed [VALUE_WIDTH-1:0] x,
        input logic signed [VALUE_WIDTH-1:0] y
    );
        logic signed [VALUE_WIDTH:0] t;
        t = {x[VALUE_WIDTH-1], x} - {y[VALUE_WIDTH-1], y};
        return t[VALUE_WIDTH-1:0];
    endfunction

    always_comb
    begin
        fall_lo = cfg.shape_is_trap ? cfg.point_c : cfg.point_b;
        fall_hi = cfg.shape_is_trap ? cfg.point_d : cfg.point_c;

        // rising edge
        lanes_next[LANE_UP].fixed     = 1'b1;
        lanes_next[LANE_UP].fixed_one = 1'b0;
        lanes_next[LANE_UP].rem       = diff(crisp_value, cfg.point_a);
        lanes_next[LANE_UP].den       = diff(cfg.point_b, cfg.point_a);
        lanes_next[LANE_UP].quo       = '0;
        if (cfg.point_b < cfg.point_a)
        begin
            lanes_next[LANE_UP].fixed_one = 1'b1;
        end
        else if (cfg.point_b == cfg.point_a)
        begin
            lanes_next[LANE_UP].fixed_one = (crisp_value >= cfg.point_a);
        end
        else if (crisp_value <= cfg.point_a)
        begin
            lanes_next[LANE_UP].fixed_one = 1'b0;
        end
        else if (crisp_value >= cfg.point_b)
        begin
            lanes_next[LANE_UP].fixed_one = 1'b1;
        end
        else
        begin
            lanes_next[LANE_UP].fixed = 1'b0;
        end

        // falling edge
        lanes_next[LANE_DOWN].fixed     = 1'b1;
        lanes_next[LANE_DOWN].fixed_one = 1'b0;
        lanes_next[LANE_DOWN].rem       = diff(fall_hi, crisp_value);
        lanes_next[LANE_DOWN].den       = diff(fall_hi, fall_lo);
        lanes_next[LANE_DOWN].quo       = '0;
        if (fall_hi < fall_lo)
        begin
            lanes_next[LANE_DOWN].fixed_one = 1'b1;
        end
        else if (fall_hi == fall_lo)
        begin
            lanes_next[LANE_DOWN].fixed_one = (crisp_value <= fall_hi);
        end
        else if (crisp_value >= fall_hi)
        begin
            lanes_next[LANE_DOWN].fixed_one = 1'b0;
        end
        else if (crisp_value <= fall_lo)
        begin
            lanes_next[LANE_DOWN].fixed_one = 1'b1;
        end
        else
        begin
            lanes_next[LANE_DOWN].fixed = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign valid_out = valid_reg;
    assign lanes_out = lanes_reg;

endmodule

/* design/fmd_div_cell.sv */
// ----------------------------------------------------------------------------
// fmd_div_cell
// one restoring division step for both edge lanes, one quotient bit per cell
// ----------------------------------------------------------------------------
module fmd_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                valid_in,
    input  fmd_pkg::fmd_lanes_t lanes_in,
    output logic                valid_out,
    output fmd_pkg::fmd_lanes_t lanes_out
);
    import fmd_pkg::*;

    logic       valid_reg;
    fmd_lanes_t lanes_reg;
    fmd_lanes_t lanes_next;

    logic [VALUE_WIDTH:0] rem2 [NUM_LANES];
    logic [VALUE_WIDTH:0] sub2 [NUM_LANES];
    logic                 ge   [NUM_LANES];

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            rem2[i] = {lanes_in[i].rem, 1'b0};
            sub2[i] = rem2[i] - {1'b0, lanes_in[i].den};
            ge[i]   = (rem2[i] >= {1'b0, lanes_in[i].den});

            lanes_next[i]     = lanes_in[i];
            lanes_next[i].rem = ge[i] ? sub2[i][VALUE_WIDTH-1:0] : rem2[i][VALUE_WIDTH-1:0];
            lanes_next[i].quo = {lanes_in[i].quo[FRAC_BITS-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign valid_out = valid_reg;
    assign lanes_out = lanes_reg;

endmodule

/* design/fuzzy_membership_degree_top.sv */
// ----------------------------------------------------------------------------
// fuzzy_membership_degree_top
// membership degree of a crisp value in a triangular or trapezoidal set
//
// sample channel takes one signed crisp value per item, result channel
// returns one unsigned Q1.15 degree per item, in order
// breakpoints and shape are written through cfg_write / cfg_index / cfg_data;
// the user must write them only while no item is in flight, the block does not enforce it
// each item passes an edge classifier stage, a row of 15 division cells
// (one quotient bit of both edges per cell) and an output register
// one item per cycle is accepted as long as the result side keeps up
// when the receiver stalls the whole row holds and sample.ready drops
// until the output register is taken
// reset clears all breakpoints to 0, selects triangle and empties the row
// ----------------------------------------------------------------------------
module fuzzy_membership_degree_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fmd_pkg::CFG_DATA_W-1:0]  cfg_data,
    fmd_in_if.sink                         sample,
    fmd_out_if.source                      result
);
    import fmd_pkg::*;

    fmd_cfg_t cfg_reg;
    fmd_cfg_t cfg_next;

    logic             adv;
    logic             out_valid_reg;
    logic [DEG_W-1:0] degree_reg;
    logic [DEG_W-1:0] degree_next;
    logic [DEG_W-1:0] up_deg;
    logic [DEG_W-1:0] down_deg;

    logic       chain_valid [FRAC_BITS+1];
    fmd_lanes_t chain_lanes [FRAC_BITS+1];

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_POINT_A: cfg_next.point_a       = cfg_data[VALUE_WIDTH-1:0];
                REG_POINT_B: cfg_next.point_b       = cfg_data[VALUE_WIDTH-1:0];
                REG_POINT_C: cfg_next.point_c       = cfg_data[VALUE_WIDTH-1:0];
                REG_POINT_D: cfg_next.point_d       = cfg_data[VALUE_WIDTH-1:0];
                REG_SHAPE:   cfg_next.shape_is_trap = cfg_data[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // whole row moves when the output register is free or being taken
    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    fmd_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .valid_in    (sample.valid),
        .crisp_value (sample.crisp_value),
        .cfg         (cfg_reg),
        .valid_out   (chain_valid[0]),
        .lanes_out   (chain_lanes[0])
    );

    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_cell
        fmd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (chain_valid[k]),
            .lanes_in  (chain_lanes[k]),
            .valid_out (chain_valid[k+1]),
            .lanes_out (chain_lanes[k+1])
        );
    end

    // smaller of the rising and falling edge degrees
    always_comb
    begin
        up_deg      = lane_degree(chain_lanes[FRAC_BITS][LANE_UP]);
        down_deg    = lane_degree(chain_lanes[FRAC_BITS][LANE_DOWN]);
        degree_next = (up_deg < down_deg) ? up_deg : down_deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            degree_reg <= degree_next;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.degree = degree_reg;

endmodule
